// ===== rtl/dnht_pkg.sv =====
// shared types, fixed-point constants and the control store of the needle tracker
// no dependencies; imported by damped_needle_heading_tracker_core, needle_track_checker and tb
package dnht_pkg;

  localparam int HEAD_W = 27;
  localparam int ANG_W  = 32;
  localparam int GAIN_W = 16;
  localparam int DT_W   = 16;
  localparam int HW_W   = 28;
  localparam int DIFF_W = 35;
  localparam int MA_W   = 36;
  localparam int MB_W   = GAIN_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = 62;
  localparam int FRAC_G = 8;
  localparam int FRAC_T = 16;
  localparam int SPLIT  = 22;
  localparam int STEP_W = 4;
  localparam int CFG_W  = 2;

  localparam logic signed [DIFF_W-1:0] DEG360 = 35'sd23592960;
  localparam logic signed [DIFF_W-1:0] DEG270 = 35'sd17694720;
  localparam logic signed [DIFF_W-1:0] DEG90  = 35'sd5898240;

  localparam logic [GAIN_W-1:0] SPRING_RST = 16'd512;
  localparam logic [GAIN_W-1:0] DRAG_RST   = 16'd230;
  localparam logic [GAIN_W-1:0] STILL_RST  = 16'd7;

  localparam logic [CFG_W-1:0] CFG_SPRING = 2'd0;
  localparam logic [CFG_W-1:0] CFG_DRAG   = 2'd1;
  localparam logic [CFG_W-1:0] CFG_STILL  = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRAP,
    OP_DIFF,
    OP_MUL_SD,
    OP_MUL_DV,
    OP_SUB,
    OP_MUL_ALO,
    OP_MUL_AHI,
    OP_ADD_HI,
    OP_VEL,
    OP_MUL_NV,
    OP_POS,
    OP_HOLD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              jump_still;
    logic [STEP_W-1:0] target;
    logic              last;
  } cw_t;

  localparam logic [STEP_W-1:0] STEP_HOLD = 4'd11;

  function automatic cw_t ucode_rom(input logic [STEP_W-1:0] step);
    cw_t cw;
    cw = '{op: OP_NOP, jump_still: 1'b0, target: '0, last: 1'b1};
    case (step)
      4'd0:  cw = '{op: OP_WRAP,    jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd1:  cw = '{op: OP_DIFF,    jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd2:  cw = '{op: OP_MUL_SD,  jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd3:  cw = '{op: OP_MUL_DV,  jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd4:  cw = '{op: OP_SUB,     jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd5:  cw = '{op: OP_MUL_ALO, jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd6:  cw = '{op: OP_MUL_AHI, jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd7:  cw = '{op: OP_ADD_HI,  jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd8:  cw = '{op: OP_VEL,     jump_still: 1'b0, target: '0,        last: 1'b0};
      4'd9:  cw = '{op: OP_MUL_NV,  jump_still: 1'b1, target: STEP_HOLD, last: 1'b0};
      4'd10: cw = '{op: OP_POS,     jump_still: 1'b0, target: '0,        last: 1'b1};
      4'd11: cw = '{op: OP_HOLD,    jump_still: 1'b0, target: '0,        last: 1'b1};
      default: cw = '{op: OP_NOP,   jump_still: 1'b0, target: '0,        last: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/damped_needle_heading_tracker_core.sv =====
// damped needle heading tracker: microcoded sequencer over one shared 36x17 multiplier
// depends on dnht_pkg (widths, constants, control store)
// each item runs eleven control-store steps, on both the moving and the still path
// a new input beat is accepted only after the previous item's final step has completed
// a result held by a stalled output delays the next item's final step only
// reset: gains and band return to 2.0, 0.9 and 7, needle position and velocity clear to zero
module damped_needle_heading_tracker_core
  import dnht_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [HEAD_W-1:0]  target_heading,
  input  logic        [DT_W-1:0]    time_step,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ANG_W-1:0]   needle_angle,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic        [CFG_W-1:0]   cfg_index,
  input  logic        [GAIN_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                    state;
  logic [STEP_W-1:0]         pc;
  cw_t                       cw;

  logic [GAIN_W-1:0]         spring_gain;
  logic [GAIN_W-1:0]         drag_gain;
  logic [GAIN_W-1:0]         still_band;
  logic signed [ANG_W-1:0]   needle_pos;
  logic signed [ANG_W-1:0]   needle_vel;

  logic signed [HEAD_W-1:0]  head_q;
  logic [DT_W-1:0]           dt_q;
  logic signed [HW_W-1:0]    hw;
  logic signed [ANG_W-1:0]   pw;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [DIFF_W-1:0]  hw_next;
  logic signed [DIFF_W-1:0]  pw_next;
  logic signed [DIFF_W-1:0]  diff_next;
  logic signed [DIFF_W-1:0]  hx;
  logic signed [DIFF_W-1:0]  px;
  logic signed [DIFF_W-1:0]  d0;
  logic signed [DIFF_W-1:0]  alt_lo;
  logic signed [DIFF_W-1:0]  alt_hi;
  logic signed [DIFF_W-1:0]  abs_lo;

  logic signed [MA_W-1:0]    mul_a;
  logic [GAIN_W-1:0]         mul_b;
  logic signed [MB_W-1:0]    mul_bs;
  logic signed [PROD_W-1:0]  mul_p;
  logic                      mul_en;

  logic signed [ACC_W-1:0]   prod_x;
  logic signed [ACC_W-1:0]   vel_sum;
  logic signed [ACC_W-1:0]   pos_sum;
  logic signed [ANG_W-1:0]   vel_next;
  logic signed [ANG_W-1:0]   pos_next;
  logic [ANG_W:0]            vel_abs;
  logic                      still;
  logic                      out_free;
  logic                      done;

  function automatic logic signed [DIFF_W-1:0] wrap_once(input logic signed [DIFF_W-1:0] x);
    logic signed [DIFF_W-1:0] y;
    y = (x < 0) ? x + DEG360 : x;
    if (y > DEG360) begin
      y = y - DEG360;
    end
    return y;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &x[ACC_W-1:ANG_W-1];
    hi_zeros = ~|x[ACC_W-1:ANG_W-1];
    if (hi_ones || hi_zeros) begin
      return x[ANG_W-1:0];
    end
    return x[ACC_W-1] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
  endfunction

  assign cw        = ucode_rom(pc);
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign done      = (state == S_RUN) && cw.last && out_free;

  // wrap and shortest signed difference across the seam
  always_comb begin
    hw_next = wrap_once({{(DIFF_W-HEAD_W){head_q[HEAD_W-1]}}, head_q});
    pw_next = wrap_once({{(DIFF_W-ANG_W){needle_pos[ANG_W-1]}}, needle_pos});
    hx      = {{(DIFF_W-HW_W){hw[HW_W-1]}}, hw};
    px      = {{(DIFF_W-ANG_W){pw[ANG_W-1]}}, pw};
    d0      = hx - px;
    alt_lo  = hx - DEG360 - px;
    alt_hi  = DEG360 - px + hx;
    abs_lo  = (alt_lo < 0) ? -alt_lo : alt_lo;
    if (hx > DEG270 && px < DEG90) begin
      diff_next = alt_lo;
    end else if (hx < DEG90 && px > DEG270) begin
      diff_next = alt_hi;
    end else if (d0 > 0) begin
      diff_next = (abs_lo < d0) ? alt_lo : d0;
    end else if (d0 < 0) begin
      diff_next = (alt_hi < -d0) ? alt_hi : d0;
    end else begin
      diff_next = d0;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = dt_q;
    mul_en = 1'b1;
    case (cw.op)
      OP_MUL_SD: begin
        mul_a = {{(MA_W-DIFF_W){diff[DIFF_W-1]}}, diff};
        mul_b = spring_gain;
      end
      OP_MUL_DV: begin
        mul_a = {{(MA_W-ANG_W){needle_vel[ANG_W-1]}}, needle_vel};
        mul_b = drag_gain;
      end
      OP_MUL_ALO: begin
        mul_a = {{(MA_W-SPLIT){1'b0}}, acc[FRAC_G+SPLIT-1:FRAC_G]};
      end
      OP_MUL_AHI: begin
        mul_a = {{(MA_W-SPLIT){acc[FRAC_G+2*SPLIT-1]}},
                 acc[FRAC_G+2*SPLIT-1:FRAC_G+SPLIT]};
      end
      OP_MUL_NV: begin
        mul_a = {{(MA_W-ANG_W){needle_vel[ANG_W-1]}}, needle_vel};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
    mul_bs = {1'b0, mul_b};
    mul_p  = mul_a * mul_bs;
  end

  always_comb begin
    prod_x   = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    vel_sum  = $signed({{(ACC_W-ANG_W){needle_vel[ANG_W-1]}}, needle_vel}) + (acc >>> FRAC_T);
    vel_next = sat32(vel_sum);
    pos_sum  = $signed({{(ACC_W-ANG_W){pw[ANG_W-1]}}, pw}) + (prod_x >>> FRAC_T);
    pos_next = (cw.op == OP_POS) ? sat32(pos_sum) : pw;
    vel_abs  = needle_vel[ANG_W-1] ? -{needle_vel[ANG_W-1], needle_vel}
                                   : {needle_vel[ANG_W-1], needle_vel};
    still    = vel_abs < {{(ANG_W+1-GAIN_W){1'b0}}, still_band};
  end

  // sequencer, configuration and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pc          <= '0;
      out_valid   <= 1'b0;
      spring_gain <= SPRING_RST;
      drag_gain   <= DRAG_RST;
      still_band  <= STILL_RST;
      needle_pos  <= '0;
      needle_vel  <= '0;
    end else begin
      if (out_valid && out_ready && !done) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SPRING: spring_gain <= cfg_data;
          CFG_DRAG:   drag_gain   <= cfg_data;
          CFG_STILL:  still_band  <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            pc    <= '0;
          end
        end
        S_RUN: begin
          if (cw.op == OP_VEL) begin
            needle_vel <= vel_next;
          end
          if (cw.last) begin
            if (out_free) begin
              out_valid  <= 1'b1;
              needle_pos <= pos_next;
              state      <= S_IDLE;
            end
          end else if (cw.jump_still && still) begin
            pc <= cw.target;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      head_q <= target_heading;
      dt_q   <= time_step;
    end
    if (state == S_RUN) begin
      if (mul_en) begin
        prod <= mul_p;
      end
      case (cw.op)
        OP_WRAP: begin
          hw <= hw_next[HW_W-1:0];
          pw <= pw_next[ANG_W-1:0];
        end
        OP_DIFF:    diff <= diff_next;
        OP_MUL_DV:  acc  <= prod_x;
        OP_SUB:     acc  <= acc - prod_x;
        OP_MUL_AHI: acc  <= prod_x;
        OP_ADD_HI:  acc  <= acc + (prod_x <<< SPLIT);
        OP_POS, OP_HOLD: begin
          if (out_free) begin
            needle_angle <= pos_next;
          end
        end
        default: ;
      endcase
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_RUN && pc == '0)
    else $error("sequencer did not start at step zero after an input beat");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> pc <= STEP_HOLD)
    else $error("step counter left the control store");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RUN) && $past(cw.last))
    else $error("result raised outside a final step");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(needle_pos))
    else $error("needle position committed while a result was still pending");

endmodule

// ===== sim/needle_track_checker.sv =====
// needle tracker checker: watches all three channels, keeps its own copy of the gains,
// needle position and velocity, predicts needle_angle and scores every output beat
// depends on dnht_pkg for widths, register indexes and angle constants
module needle_track_checker
  import dnht_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [HEAD_W-1:0] target_heading,
  input  logic        [DT_W-1:0]   time_step,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [ANG_W-1:0]  needle_angle,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic        [CFG_W-1:0]  cfg_index,
  input  logic        [GAIN_W-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TURN    = longint'(DEG360);
  localparam longint QUARTER = longint'(DEG90);
  localparam longint THREE_Q = longint'(DEG270);
  localparam longint ANG_MAX = 64'sd2147483647;
  localparam longint ANG_MIN = -64'sd2147483648;

  logic        [GAIN_W-1:0] spring_q;
  logic        [GAIN_W-1:0] drag_q;
  logic        [GAIN_W-1:0] band_q;
  logic signed [ANG_W-1:0]  pos_q;
  logic signed [ANG_W-1:0]  vel_q;
  logic signed [ANG_W-1:0]  angle_due[$];
  logic signed [ANG_W-1:0]  want;

  function automatic longint wrap_turn(input longint x);
    longint y;
    y = x;
    if (y < 0) y = y + TURN;
    if (y > TURN) y = y - TURN;
    return y;
  endfunction

  function automatic longint clamp_angle(input longint x);
    if (x > ANG_MAX) return ANG_MAX;
    if (x < ANG_MIN) return ANG_MIN;
    return x;
  endfunction

  // one spring-damper step; updates the mirrored position and velocity
  function automatic logic signed [ANG_W-1:0] advance_needle(
    input logic signed [HEAD_W-1:0] heading,
    input logic        [DT_W-1:0]   dt
  );
    longint h;
    longint p;
    longint d;
    longint alt;
    longint accel;
    longint nv;
    longint np;
    longint dtl;
    h   = wrap_turn(longint'(heading));
    p   = wrap_turn(longint'(pos_q));
    dtl = longint'(dt);
    d   = h - p;
    if (h > THREE_Q && p < QUARTER) begin
      d = h - TURN - p;
    end else if (h < QUARTER && p > THREE_Q) begin
      d = h + TURN - p;
    end else if (d > 0) begin
      alt = h - TURN - p;
      if ((alt < 0 ? -alt : alt) < d) d = alt;
    end else if (d < 0) begin
      alt = TURN - p + h;
      if (alt < -d) d = alt;
    end
    accel = (longint'(spring_q) * d - longint'(drag_q) * longint'(vel_q)) >>> FRAC_G;
    nv = clamp_angle(longint'(vel_q) + ((accel * dtl) >>> FRAC_T));
    if ((nv < 0 ? -nv : nv) < longint'(band_q)) begin
      np = p;
    end else begin
      np = clamp_angle(p + ((nv * dtl) >>> FRAC_T));
    end
    vel_q = nv[ANG_W-1:0];
    pos_q = np[ANG_W-1:0];
    return np[ANG_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      spring_q     = SPRING_RST;
      drag_q       = DRAG_RST;
      band_q       = STILL_RST;
      pos_q        = '0;
      vel_q        = '0;
      angle_due.delete();
      pending      = 0;
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPRING: spring_q = cfg_data;
          CFG_DRAG:   drag_q   = cfg_data;
          CFG_STILL:  band_q   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (angle_due.size() == 0) begin
          $error("needle_angle: expected nothing, actual %0d", needle_angle);
          fail_count++;
        end else begin
          want = angle_due.pop_front();
          if (needle_angle !== want) begin
            $error("needle_angle: expected %0d, actual %0d", want, needle_angle);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        angle_due = {angle_due, advance_needle(target_heading, time_step)};
      end
      pending = angle_due.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// testbench top for damped_needle_heading_tracker_core: drives headings and gain writes
// with random gaps and backpressure, and reports the verdict from needle_track_checker
// depends on dnht_pkg, damped_needle_heading_tracker_core and needle_track_checker
module tb;
  import dnht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_W-1:0]         CFG_UNUSED = 2'd3;
  localparam logic signed [HEAD_W-1:0] H_MIN      = 27'h4000000;
  localparam logic signed [HEAD_W-1:0] H_MAX      = 27'h3FFFFFF;
  localparam logic signed [HEAD_W-1:0] H_NEG1     = 27'h7FFFFFF;
  localparam logic signed [HEAD_W-1:0] H_10       = 27'sd655360;
  localparam logic signed [HEAD_W-1:0] H_180      = 27'sd11796480;
  localparam logic signed [HEAD_W-1:0] H_350      = 27'sd22937600;
  localparam logic signed [HEAD_W-1:0] H_NEG90    = -27'sd5898240;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [HEAD_W-1:0] target_heading;
  logic        [DT_W-1:0]   time_step;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [ANG_W-1:0]  needle_angle;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic        [CFG_W-1:0]  cfg_index;
  logic        [GAIN_W-1:0] cfg_data;

  int   fail_count;
  int   angles_owed;
  int   results_seen;
  int   cycles;
  int   n_items    = 0;
  int   n_writes   = 0;
  int   n_settings = 0;
  logic tx_quiet   = 1'b0;
  logic rx_quiet   = 1'b0;
  logic stall_req  = 1'b0;

  damped_needle_heading_tracker_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_heading (target_heading),
    .time_step      (time_step),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .needle_angle   (needle_angle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  needle_track_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .target_heading (target_heading),
    .time_step      (time_step),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .needle_angle   (needle_angle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (angles_owed),
    .results_seen   (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // output side: random gap after each beat, plus a long hold on request
  initial begin
    int unsigned rx_gap;
    int unsigned stall_left;
    logic        took;
    logic        stall_taken;
    rx_gap      = 0;
    stall_left  = 0;
    stall_taken = 1'b0;
    out_ready   = 1'b0;
    forever begin
      @(posedge clk);
      took = out_valid && out_ready;
      @(negedge clk);
      if (took) rx_gap = rx_quiet ? 0 : $urandom_range(0, 8);
      if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left  = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready = 1'b0;
      end else begin
        out_ready = !rst;
      end
    end
  end

  task automatic send_heading(input logic signed [HEAD_W-1:0] h, input logic [DT_W-1:0] dt);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    target_heading = h;
    time_step      = dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  task automatic wait_all_angles();
    in_valid = 1'b0;
    while (angles_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_writes++;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] spring, input logic [GAIN_W-1:0] drag,
                           input logic [GAIN_W-1:0] band);
    wait_all_angles();
    write_reg(CFG_SPRING, spring);
    write_reg(CFG_DRAG, drag);
    write_reg(CFG_STILL, band);
    n_settings++;
  endtask

  task automatic pick_heading(output logic signed [HEAD_W-1:0] h, output logic [DT_W-1:0] dt);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      h = HEAD_W'($urandom_range(0, 23592960));
    end else if (sel < 80) begin
      h = HEAD_W'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0:       h = '0;
        1:       h = HEAD_W'(DEG90);
        2:       h = HEAD_W'(DEG270);
        default: h = HEAD_W'(DEG360);
      endcase
      h = h + HEAD_W'($urandom_range(0, 64)) - 27'sd32;
    end
    sel = $urandom_range(0, 99);
    if (sel < 60) dt = DT_W'($urandom_range(0, 4096));
    else if (sel < 75) dt = DT_W'($urandom());
    else if (sel < 85) dt = '0;
    else if (sel < 95) dt = '1;
    else dt = DT_W'($urandom_range(1, 16));
  endtask

  task automatic run_random(input int count);
    logic signed [HEAD_W-1:0] h;
    logic        [DT_W-1:0]   dt;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      pick_heading(h, dt);
      send_heading(h, dt);
    end
  endtask

  initial begin
    in_valid       = 1'b0;
    target_heading = '0;
    time_step      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_SPRING;
    cfg_data       = '0;
    rst            = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset gains: hold, both seam crossings, out-of-range headings, boundaries
    send_heading('0, '0);
    send_heading(H_350, 16'd256);
    send_heading(H_10, 16'd256);
    send_heading(H_NEG1, '1);
    send_heading(H_MAX, '1);
    send_heading(H_MIN, 16'd1);
    send_heading(HEAD_W'(DEG360), 16'd100);
    send_heading(HEAD_W'(DEG90), 16'd100);
    send_heading(HEAD_W'(DEG270), 16'd100);
    send_heading(H_180, '1);
    run_random(60);
    wait_all_angles();
    run_random(60);

    // full spring, no drag: drive velocity and position into saturation both ways
    set_gains('1, '0, '0);
    repeat (4) send_heading(H_180, '1);
    repeat (4) send_heading(H_NEG90, '1);
    run_random(40);

    set_gains('0, '1, '1);
    write_reg(CFG_UNUSED, 16'h1234);
    run_random(50);

    set_gains('0, '0, '0);
    run_random(30);

    for (int k = 0; k < 4; k++) begin
      set_gains(GAIN_W'($urandom_range(0, 2048)), GAIN_W'($urandom_range(0, 1024)),
                GAIN_W'($urandom_range(0, 512)));
      if (k == 1) stall_req = 1'b1;
      run_random(60);
    end

    set_gains(SPRING_RST, DRAG_RST, STILL_RST);
    run_random(60);

    wait_all_angles();
    repeat (20) @(negedge clk);
    $display("needle run: %0d heading beats, %0d angle beats, %0d register writes, %0d settings",
             n_items, results_seen, n_writes, n_settings);
    $display("exercised seam wrap, out-of-range headings, deadband, saturation and backpressure");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
